// ===== hdl/x86dec_pkg.sv =====
// Shared types, codes and classification functions of the 16-bit x86 decoder.
`default_nettype none
package x86dec_pkg;

    typedef enum logic [3:0] {
        K_BAD    = 4'd0,
        K_MOVRM  = 4'd1,
        K_MOVIR  = 4'd2,
        K_MOVIM  = 4'd3,
        K_MOVAM  = 4'd4,
        K_MOVMA  = 4'd5,
        K_ALURM  = 4'd6,
        K_ALUIM  = 4'd7,
        K_ALUACC = 4'd8,
        K_JCC    = 4'd9,
        K_LOOP   = 4'd10
    } kind_t;

    localparam logic [4:0] OP_MOV  = 5'd0;
    localparam logic [4:0] OP_ADD  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_CMP  = 5'd3;
    localparam logic [4:0] OP_JCC  = 5'd4;
    localparam logic [4:0] OP_LOOP = 5'd20;

    localparam logic [1:0] SRC_REG   = 2'd0;
    localparam logic [1:0] SRC_MEM   = 2'd1;
    localparam logic [1:0] SRC_IMM8  = 2'd2;
    localparam logic [1:0] SRC_IMM16 = 2'd3;

    localparam logic [3:0] BASE_DIRECT = 4'd8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Completed instruction handed from the front to the back.
    typedef struct packed {
        logic       bad;
        logic [7:0] opcode;
        logic [7:0] modrm;
        logic [7:0] disp_lo;
        logic [7:0] disp_hi;
        logic [7:0] imm_lo;
        logic [7:0] last;
    } instr_t;

    function automatic kind_t classify(input logic [7:0] o);
        kind_t k;
        if ((o & 8'hFC) == 8'h88)      k = K_MOVRM;
        else if ((o & 8'hF0) == 8'hB0) k = K_MOVIR;
        else if ((o & 8'hFE) == 8'hC6) k = K_MOVIM;
        else if ((o & 8'hFE) == 8'hA0) k = K_MOVAM;
        else if ((o & 8'hFE) == 8'hA2) k = K_MOVMA;
        else if ((o & 8'hC4) == 8'h00) k = K_ALURM;
        else if ((o & 8'hFC) == 8'h80) k = K_ALUIM;
        else if ((o & 8'hC6) == 8'h04) k = K_ALUACC;
        else if ((o & 8'hF0) == 8'h70) k = K_JCC;
        else if ((o & 8'hFC) == 8'hE0) k = K_LOOP;
        else                           k = K_BAD;
        return k;
    endfunction

    function automatic logic has_modrm(input kind_t k);
        return k == K_MOVRM || k == K_MOVIM || k == K_ALURM || k == K_ALUIM;
    endfunction

    function automatic logic [1:0] disp_len(input kind_t k, input logic [7:0] m);
        logic [1:0] n;
        if (k == K_MOVAM || k == K_MOVMA)     n = 2'd2;
        else if (!has_modrm(k))               n = 2'd0;
        else if (m[7:6] == 2'd1)              n = 2'd1;
        else if (m[7:6] == 2'd2)              n = 2'd2;
        else if (m[7:6] == 2'd0 && m[2:0] == 3'b110) n = 2'd2;
        else                                  n = 2'd0;
        return n;
    endfunction

    function automatic logic [1:0] imm_len(input kind_t k, input logic [7:0] o);
        logic [1:0] n;
        case (k)
            K_MOVIM, K_ALUACC: n = o[0] ? 2'd2 : 2'd1;
            K_ALUIM:           n = (o[1:0] == 2'b01) ? 2'd2 : 2'd1;
            K_MOVIR:           n = o[3] ? 2'd2 : 2'd1;
            K_JCC, K_LOOP:     n = 2'd1;
            default:           n = 2'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/x86dec_front.sv =====
// Front end: collects code bytes and hands off each complete instruction or unknown first byte.
`default_nettype none
module x86dec_front
    import x86dec_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire logic [7:0] code_byte,
    output logic        push,
    output instr_t      push_data,
    input  wire logic   full
);

    logic [2:0] taken_reg, taken_next;
    logic [2:0] expected_reg, expected_next;
    logic [7:0] opcode_reg, modrm_reg, disp_lo_reg, disp_hi_reg, imm_lo_reg;
    logic [7:0] opcode_next, modrm_next, disp_lo_next, disp_hi_next, imm_lo_next;
    kind_t      k_byte, k_op;
    logic       accept;
    logic [1:0] dl;
    logic [2:0] kk;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign k_byte   = classify(code_byte);
    assign k_op     = classify(opcode_reg);
    assign dl       = disp_len(k_op, modrm_reg);
    assign kk       = taken_reg - (has_modrm(k_op) ? 3'd2 : 3'd1);

    always_comb
    begin
        taken_next    = taken_reg;
        expected_next = expected_reg;
        opcode_next   = opcode_reg;
        modrm_next    = modrm_reg;
        disp_lo_next  = disp_lo_reg;
        disp_hi_next  = disp_hi_reg;
        imm_lo_next   = imm_lo_reg;
        push          = 1'b0;
        if (accept)
        begin
            if (taken_reg == 3'd0)
            begin
                if (k_byte == K_BAD)
                begin
                    push = 1'b1;
                end
                else
                begin
                    opcode_next   = code_byte;
                    expected_next = has_modrm(k_byte) ? 3'd2
                        : 3'd1 + {1'b0, disp_len(k_byte, 8'd0)}
                               + {1'b0, imm_len(k_byte, code_byte)};
                    taken_next    = 3'd1;
                end
            end
            else
            begin
                if (has_modrm(k_op) && taken_reg == 3'd1)
                begin
                    modrm_next    = code_byte;
                    expected_next = 3'd2 + {1'b0, disp_len(k_op, code_byte)}
                                         + {1'b0, imm_len(k_op, opcode_reg)};
                end
                else if (kk < {1'b0, dl})
                begin
                    if (kk == 3'd0) disp_lo_next = code_byte;
                    else            disp_hi_next = code_byte;
                end
                else if (kk == {1'b0, dl})
                begin
                    imm_lo_next = code_byte;
                end
                taken_next = taken_reg + 3'd1;
                if (taken_next >= expected_next)
                begin
                    push       = 1'b1;
                    taken_next = 3'd0;
                end
            end
        end
    end

    always_comb
    begin
        push_data.bad     = (taken_reg == 3'd0);
        push_data.opcode  = opcode_next;
        push_data.modrm   = modrm_next;
        push_data.disp_lo = disp_lo_next;
        push_data.disp_hi = disp_hi_next;
        push_data.imm_lo  = imm_lo_next;
        push_data.last    = code_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg    <= 3'd0;
            expected_reg <= 3'd0;
            opcode_reg   <= 8'd0;
            modrm_reg    <= 8'd0;
            disp_lo_reg  <= 8'd0;
            disp_hi_reg  <= 8'd0;
            imm_lo_reg   <= 8'd0;
        end
        else
        begin
            taken_reg    <= taken_next;
            expected_reg <= expected_next;
            opcode_reg   <= opcode_next;
            modrm_reg    <= modrm_next;
            disp_lo_reg  <= disp_lo_next;
            disp_hi_reg  <= disp_hi_next;
            imm_lo_reg   <= imm_lo_next;
        end
    end

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= 3'd6)
        else $error("byte count out of range");
    a_bad_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && taken_reg == 3'd0 && k_byte == K_BAD) |-> push)
        else $error("unknown opcode not reported");
    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> !push)
        else $error("push without byte");

endmodule
`default_nettype wire

// ===== hdl/x86dec_queue.sv =====
// Short queue between the front and back end.
`default_nettype none
module x86dec_queue
    import x86dec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  instr_t    push_data,
    output logic      full,
    output logic      not_empty,
    output instr_t    head,
    input  wire logic pop
);

    instr_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, rd_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            count_reg <= count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== hdl/x86dec_back.sv =====
// Back end: builds the decoded record and holds it in the output register.
`default_nettype none
module x86dec_back
    import x86dec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic not_empty,
    input  instr_t    head,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic             status,
    output logic [4:0]       operation,
    output logic             dest_kind,
    output logic [3:0]       dest_register,
    output logic [1:0]       src_kind,
    output logic [3:0]       src_register,
    output logic [3:0]       memory_base,
    output logic [15:0]      displacement,
    output logic [15:0]      immediate_value,
    output logic signed [7:0] jump_offset
);

    logic        valid_reg;
    logic        st;
    logic [4:0]  op;
    logic        dk;
    logic [3:0]  dr, sr, mb;
    logic [1:0]  sk;
    logic [15:0] disp, imm;
    logic [7:0]  jo;
    kind_t       k;
    logic        w, d;
    logic [2:0]  regf, sel;
    logic [1:0]  mode;
    logic [2:0]  rm;
    logic        rm_mem;
    logic [3:0]  rm_reg, rm_base;
    logic [15:0] rm_disp;
    logic        alu_ok;
    logic [4:0]  alu_code;
    logic        load;

    assign out_valid = valid_reg;
    assign load      = not_empty && (!valid_reg || !out_stall);
    assign pop       = load;

    always_comb
    begin
        k    = classify(head.opcode);
        w    = head.opcode[0];
        d    = head.opcode[1];
        regf = head.modrm[5:3];
        mode = head.modrm[7:6];
        rm   = head.modrm[2:0];
        rm_mem  = (mode != 2'd3);
        rm_reg  = {w, rm};
        rm_base = (mode == 2'd0 && rm == 3'b110) ? BASE_DIRECT : {1'b0, rm};
        case (disp_len(k, head.modrm))
            2'd1:    rm_disp = {{8{head.disp_lo[7]}}, head.disp_lo};
            2'd2:    rm_disp = {head.disp_hi, head.disp_lo};
            default: rm_disp = 16'd0;
        endcase
        sel = (k == K_ALUIM) ? regf : head.opcode[5:3];
        alu_ok = 1'b1;
        case (sel)
            3'd0:    alu_code = OP_ADD;
            3'd5:    alu_code = OP_SUB;
            3'd7:    alu_code = OP_CMP;
            default:
            begin
                alu_code = OP_MOV;
                alu_ok   = 1'b0;
            end
        endcase
        if (!(k == K_ALURM || k == K_ALUIM || k == K_ALUACC)) alu_ok = 1'b1;

        st = 1'b0; op = OP_MOV; dk = 1'b0; dr = 4'd0; sk = SRC_REG; sr = 4'd0;
        mb = 4'd0; disp = 16'd0; imm = 16'd0; jo = 8'd0;
        if (imm_len(k, head.opcode) == 2'd2)
        begin
            sk  = SRC_IMM16;
            imm = {head.last, head.imm_lo};
        end
        else if (k == K_ALUIM && head.opcode[1:0] == 2'b11)
        begin
            sk  = SRC_IMM16;
            imm = {{8{head.imm_lo[7]}}, head.imm_lo};
        end
        else
        begin
            sk  = SRC_IMM8;
            imm = {8'd0, head.imm_lo};
        end
        if (head.bad || !alu_ok)
        begin
            st = 1'b1; sk = SRC_REG; imm = 16'd0;
        end
        else
        begin
            case (k)
                K_MOVRM, K_ALURM:
                begin
                    op = (k == K_ALURM) ? alu_code : OP_MOV;
                    imm = 16'd0;
                    if (rm_mem)
                    begin
                        mb = rm_base; disp = rm_disp;
                    end
                    if (d)
                    begin
                        dr = {w, regf};
                        sk = rm_mem ? SRC_MEM : SRC_REG;
                        sr = rm_mem ? 4'd0 : rm_reg;
                    end
                    else
                    begin
                        sk = SRC_REG;
                        sr = {w, regf};
                        dk = rm_mem;
                        dr = rm_mem ? 4'd0 : rm_reg;
                    end
                end
                K_MOVIM, K_ALUIM:
                begin
                    op = (k == K_ALUIM) ? alu_code : OP_MOV;
                    dk = rm_mem;
                    dr = rm_mem ? 4'd0 : rm_reg;
                    if (rm_mem)
                    begin
                        mb = rm_base; disp = rm_disp;
                    end
                end
                K_MOVIR:
                    dr = {head.opcode[3], head.opcode[2:0]};
                K_ALUACC:
                begin
                    op = alu_code;
                    dr = {w, 3'd0};
                end
                K_MOVAM:
                begin
                    dr = {w, 3'd0}; sk = SRC_MEM; imm = 16'd0;
                    mb = BASE_DIRECT; disp = {head.disp_hi, head.disp_lo};
                end
                K_MOVMA:
                begin
                    dk = 1'b1; sk = SRC_REG; sr = {w, 3'd0}; imm = 16'd0;
                    mb = BASE_DIRECT; disp = {head.disp_hi, head.disp_lo};
                end
                K_JCC:
                begin
                    op = OP_JCC + {1'b0, head.opcode[3:0]};
                    sk = SRC_REG; imm = 16'd0; jo = head.imm_lo;
                end
                default:
                begin
                    op = OP_LOOP + {3'd0, head.opcode[1:0]};
                    sk = SRC_REG; imm = 16'd0; jo = head.imm_lo;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status          <= st;
            operation       <= op;
            dest_kind       <= dk;
            dest_register   <= dr;
            src_kind        <= sk;
            src_register    <= sr;
            memory_base     <= mb;
            displacement    <= disp;
            immediate_value <= imm;
            jump_offset     <= jo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (operation == OP_MOV && displacement == 16'd0))
        else $error("unknown record carries fields");
    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hdl/x86_16bit_instruction_decoder_unit.sv =====
// Top level of the streaming 16-bit x86 instruction decoder.
// Takes one code byte per item and emits one decoded record per instruction
// (MOV forms, ADD/SUB/CMP, Jcc, LOOP family); an unknown first byte gives
// a status-1 record at once. Bytes are accepted one per cycle unless the
// queue is full: the front end updates the byte count and partial fields,
// a two-entry queue carries complete instructions to the back end, which
// forms the record into the output register. A record passes through a
// queue slot and then the output register after its last byte; stalls on
// the output side back up through the queue to the input stall.
`default_nettype none
module x86_16bit_instruction_decoder_unit
    import x86dec_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic [7:0] code_byte,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic             status,
    output logic [4:0]       operation,
    output logic             dest_kind,
    output logic [3:0]       dest_register,
    output logic [1:0]       src_kind,
    output logic [3:0]       src_register,
    output logic [3:0]       memory_base,
    output logic [15:0]      displacement,
    output logic [15:0]      immediate_value,
    output logic signed [7:0] jump_offset
);

    // Hand-off signals between the front end, the queue and the back end.
    logic   push, full, not_empty, pop;
    instr_t push_data, head;

    x86dec_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .code_byte(code_byte), .push(push), .push_data(push_data), .full(full)
    );

    x86dec_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .full(full), .not_empty(not_empty), .head(head), .pop(pop)
    );

    x86dec_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head(head), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .operation(operation), .dest_kind(dest_kind),
        .dest_register(dest_register), .src_kind(src_kind),
        .src_register(src_register), .memory_base(memory_base),
        .displacement(displacement), .immediate_value(immediate_value),
        .jump_offset(jump_offset)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the streaming 16-bit x86 instruction decoder.
`default_nettype none

// Holds decoded records predicted from accepted bytes and checks the block's records.
class decode_board;
    typedef struct packed {
        logic        status;
        logic [4:0]  operation;
        logic        dest_kind;
        logic [3:0]  dest_register;
        logic [1:0]  src_kind;
        logic [3:0]  src_register;
        logic [3:0]  memory_base;
        logic [15:0] displacement;
        logic [15:0] immediate_value;
        logic [7:0]  jump_offset;
    } record_t;

    record_t pending_records[$];
    int      mismatches;
    bit [2:0] taken;
    bit [2:0] expected_len;
    bit [7:0] opc;
    bit [7:0] modrm;
    bit [7:0] disp_lo;
    bit [7:0] disp_hi;
    bit [7:0] imm_lo;

    function new();
        mismatches = 0;
        taken = 0;
        expected_len = 0;
        opc = 0;
        modrm = 0;
        disp_lo = 0;
        disp_hi = 0;
        imm_lo = 0;
    endfunction

    function automatic int kind_of(bit [7:0] o);
        if ((o & 8'hFC) == 8'h88) return 1;
        if ((o & 8'hF0) == 8'hB0) return 2;
        if ((o & 8'hFE) == 8'hC6) return 3;
        if ((o & 8'hFE) == 8'hA0) return 4;
        if ((o & 8'hFE) == 8'hA2) return 5;
        if ((o & 8'hC4) == 8'h00) return 6;
        if ((o & 8'hFC) == 8'h80) return 7;
        if ((o & 8'hC6) == 8'h04) return 8;
        if ((o & 8'hF0) == 8'h70) return 9;
        if ((o & 8'hFC) == 8'hE0) return 10;
        return 0;
    endfunction

    function automatic bit takes_modrm(int k);
        return k == 1 || k == 3 || k == 6 || k == 7;
    endfunction

    function automatic int disp_bytes(int k, bit [7:0] m);
        if (k == 4 || k == 5) return 2;
        if (!takes_modrm(k)) return 0;
        if (m[7:6] == 2'd1) return 1;
        if (m[7:6] == 2'd2) return 2;
        if (m[7:6] == 2'd0 && m[2:0] == 3'd6) return 2;
        return 0;
    endfunction

    function automatic int imm_bytes(int k, bit [7:0] o);
        case (k)
            3, 8: return o[0] ? 2 : 1;
            7: return (o[1:0] == 2'b01) ? 2 : 1;
            2: return o[3] ? 2 : 1;
            9, 10: return 1;
            default: return 0;
        endcase
    endfunction

    // Fill the rm operand into dest (to_dest) or source slots.
    function automatic void rm_slot(ref record_t r, input bit to_dest, input int k,
                                    input bit w);
        int dl;
        dl = disp_bytes(k, modrm);
        if (modrm[7:6] == 2'd3) begin
            if (to_dest) r.dest_register = {w, modrm[2:0]};
            else r.src_register = {w, modrm[2:0]};
            return;
        end
        if (to_dest) r.dest_kind = 1'b1;
        else r.src_kind = x86dec_pkg::SRC_MEM;
        r.memory_base = (modrm[7:6] == 2'd0 && modrm[2:0] == 3'd6) ?
                        x86dec_pkg::BASE_DIRECT : {1'b0, modrm[2:0]};
        if (dl == 1) r.displacement = {{8{disp_lo[7]}}, disp_lo};
        else if (dl == 2) r.displacement = {disp_hi, disp_lo};
    endfunction

    function automatic void imm_slot(ref record_t r, input int k, input bit [7:0] last);
        if (imm_bytes(k, opc) == 2) begin
            r.src_kind = x86dec_pkg::SRC_IMM16;
            r.immediate_value = {last, imm_lo};
        end else if (k == 7 && opc[1:0] == 2'b11) begin
            r.src_kind = x86dec_pkg::SRC_IMM16;
            r.immediate_value = {{8{imm_lo[7]}}, imm_lo};
        end else begin
            r.src_kind = x86dec_pkg::SRC_IMM8;
            r.immediate_value = {8'h00, imm_lo};
        end
    endfunction

    function automatic record_t build_record(bit [7:0] last);
        record_t r;
        int k;
        bit w;
        bit [2:0] alu;
        bit [4:0] op;
        r = '0;
        k = kind_of(opc);
        w = opc[0];
        op = x86dec_pkg::OP_MOV;
        alu = (k == 7) ? modrm[5:3] : opc[5:3];
        if (k == 6 || k == 7 || k == 8) begin
            if (alu == 3'd0) op = x86dec_pkg::OP_ADD;
            else if (alu == 3'd5) op = x86dec_pkg::OP_SUB;
            else if (alu == 3'd7) op = x86dec_pkg::OP_CMP;
            else begin
                r.status = 1'b1;
                return r;
            end
        end
        case (k)
            1, 6: begin
                if (opc[1]) begin
                    r.dest_register = {w, modrm[5:3]};
                    rm_slot(r, 1'b0, k, w);
                end else begin
                    r.src_register = {w, modrm[5:3]};
                    rm_slot(r, 1'b1, k, w);
                end
            end
            3, 7: begin
                rm_slot(r, 1'b1, k, w);
                imm_slot(r, k, last);
            end
            2: begin
                r.dest_register = opc[3:0];
                imm_slot(r, k, last);
            end
            8: begin
                r.dest_register = {w, 3'd0};
                imm_slot(r, k, last);
            end
            4: begin
                r.dest_register = {w, 3'd0};
                r.src_kind = x86dec_pkg::SRC_MEM;
                r.memory_base = x86dec_pkg::BASE_DIRECT;
                r.displacement = {disp_hi, disp_lo};
            end
            5: begin
                r.dest_kind = 1'b1;
                r.src_register = {w, 3'd0};
                r.memory_base = x86dec_pkg::BASE_DIRECT;
                r.displacement = {disp_hi, disp_lo};
            end
            9: begin
                op = x86dec_pkg::OP_JCC + opc[3:0];
                r.jump_offset = imm_lo;
            end
            default: begin
                op = x86dec_pkg::OP_LOOP + opc[1:0];
                r.jump_offset = imm_lo;
            end
        endcase
        r.operation = op;
        return r;
    endfunction

    // Advance the decode state by one accepted byte.
    function void note_byte(bit [7:0] b);
        int k;
        int dl;
        int kk;
        record_t r;
        if (taken == 0) begin
            k = kind_of(b);
            if (k == 0) begin
                r = '0;
                r.status = 1'b1;
                pending_records.push_back(r);
                return;
            end
            opc = b;
            expected_len = takes_modrm(k) ? 3'd2 : 3'(1 + disp_bytes(k, 8'h00) + imm_bytes(k, b));
            taken = 1;
            return;
        end
        k = kind_of(opc);
        if (takes_modrm(k) && taken == 1) begin
            modrm = b;
            expected_len = 3'(2 + disp_bytes(k, b) + imm_bytes(k, opc));
        end else begin
            dl = disp_bytes(k, modrm);
            kk = int'(taken) - (takes_modrm(k) ? 2 : 1);
            if (kk < dl) begin
                if (kk == 0) disp_lo = b;
                else disp_hi = b;
            end else if (kk == dl) imm_lo = b;
        end
        taken = taken + 3'd1;
        if (taken >= expected_len) begin
            pending_records.push_back(build_record(b));
            taken = 0;
        end
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    task check_record(record_t got);
        record_t want;
        if (pending_records.size() == 0) begin
            report("record with none expected", 16'(got.operation), 16'd0);
            return;
        end
        want = pending_records.pop_front();
        if (got.status !== want.status)
            report("status", 16'(got.status), 16'(want.status));
        if (got.operation !== want.operation)
            report("operation", 16'(got.operation), 16'(want.operation));
        if (got.dest_kind !== want.dest_kind)
            report("dest_kind", 16'(got.dest_kind), 16'(want.dest_kind));
        if (got.dest_register !== want.dest_register)
            report("dest_register", 16'(got.dest_register), 16'(want.dest_register));
        if (got.src_kind !== want.src_kind)
            report("src_kind", 16'(got.src_kind), 16'(want.src_kind));
        if (got.src_register !== want.src_register)
            report("src_register", 16'(got.src_register), 16'(want.src_register));
        if (got.memory_base !== want.memory_base)
            report("memory_base", 16'(got.memory_base), 16'(want.memory_base));
        if (got.displacement !== want.displacement)
            report("displacement", got.displacement, want.displacement);
        if (got.immediate_value !== want.immediate_value)
            report("immediate_value", got.immediate_value, want.immediate_value);
        if (got.jump_offset !== want.jump_offset)
            report("jump_offset", 16'(got.jump_offset), 16'(want.jump_offset));
    endtask
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] code_byte;
    logic out_valid;
    logic out_stall;
    logic status;
    logic [4:0] operation;
    logic dest_kind;
    logic [3:0] dest_register;
    logic [1:0] src_kind;
    logic [3:0] src_register;
    logic [3:0] memory_base;
    logic [15:0] displacement;
    logic [15:0] immediate_value;
    logic signed [7:0] jump_offset;

    decode_board board;
    logic [7:0] byte_stream[$];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int quiet_cycles;

    x86_16bit_instruction_decoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .code_byte(code_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .operation(operation), .dest_kind(dest_kind),
        .dest_register(dest_register), .src_kind(src_kind),
        .src_register(src_register), .memory_base(memory_base),
        .displacement(displacement), .immediate_value(immediate_value),
        .jump_offset(jump_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue an instruction with random content; pick a form at random (the last form is a random byte).
    task automatic queue_instruction();
        logic [7:0] o;
        logic [7:0] m;
        int form;
        int k;
        int n;
        form = $urandom_range(0, 9);
        case (form)
            0: o = 8'h88 | 8'($urandom_range(0, 3));
            1: o = 8'hB0 | 8'($urandom_range(0, 15));
            2: o = 8'hC6 | 8'($urandom_range(0, 1));
            3: o = 8'hA0 | 8'($urandom_range(0, 3));
            4: o = {2'b00, 3'($urandom_range(0, 7)), 1'b0, 2'($urandom_range(0, 3))};
            5: o = 8'h80 | 8'($urandom_range(0, 3));
            6: o = {2'b00, 3'($urandom_range(0, 7)), 2'b10, 1'($urandom_range(0, 1))};
            7: o = 8'h70 | 8'($urandom_range(0, 15));
            8: o = 8'hE0 | 8'($urandom_range(0, 3));
            default: o = 8'($urandom);
        endcase
        byte_stream.push_back(o);
        k = board.kind_of(o);
        if (k == 0) return;
        m = 8'($urandom);
        // Favor add/sub/cmp in the immediate group so most records decode.
        if (k == 7 && $urandom_range(0, 3) != 0) m[5:3] = 3'($urandom_range(0, 2)) == 0 ? 3'd0 :
                                                     ($urandom_range(0, 1) ? 3'd5 : 3'd7);
        if (board.takes_modrm(k)) begin
            byte_stream.push_back(m);
            n = board.disp_bytes(k, m) + board.imm_bytes(k, o);
        end else n = board.disp_bytes(k, 8'h00) + board.imm_bytes(k, o);
        repeat (n) byte_stream.push_back(8'($urandom));
    endtask

    // Directed opener: each form but the ALU register/memory one, field extremes, the special cases.
    task automatic queue_directed();
        byte_stream.push_back(8'h0F);                       // unknown first byte
        byte_stream.push_back(8'hFF);                       // unknown first byte, all ones
        byte_stream.push_back(8'h89); byte_stream.push_back(8'hD8);  // mov ax,bx
        byte_stream.push_back(8'h8A); byte_stream.push_back(8'h06);  // mov al,[direct]
        byte_stream.push_back(8'h00); byte_stream.push_back(8'hFF);
        byte_stream.push_back(8'hBF); byte_stream.push_back(8'hFF);  // mov di,imm16
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(8'hC7); byte_stream.push_back(8'h7F);  // reg field ignored
        byte_stream.push_back(8'h80); byte_stream.push_back(8'h34);
        byte_stream.push_back(8'h12);
        byte_stream.push_back(8'hA0); byte_stream.push_back(8'h34);  // narrow acc move
        byte_stream.push_back(8'h12);
        byte_stream.push_back(8'hA3); byte_stream.push_back(8'h00);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'h83); byte_stream.push_back(8'h44);  // sign-extended imm
        byte_stream.push_back(8'h80); byte_stream.push_back(8'h80);
        byte_stream.push_back(8'h80); byte_stream.push_back(8'hC8);  // or: unsupported
        byte_stream.push_back(8'h01);
        byte_stream.push_back(8'h2D); byte_stream.push_back(8'h01);  // sub ax,imm16
        byte_stream.push_back(8'h80);
        byte_stream.push_back(8'h3C); byte_stream.push_back(8'h7F);  // cmp al,imm8
        byte_stream.push_back(8'h7F); byte_stream.push_back(8'h80);  // jg -128
        byte_stream.push_back(8'hE3); byte_stream.push_back(8'h7F);  // jcxz +127
    endtask

    task automatic send_bytes();
        logic [7:0] b;
        while (byte_stream.size() > 0)
        begin
            b = byte_stream.pop_front();
            in_valid <= 1'b1;
            code_byte <= b;
            do @(posedge clk); while (in_stall);
            board.note_byte(b);
            // Drop valid and idle after the last item, or at random before the next item.
            if (byte_stream.size() == 0 || $urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(0, 99) < send_idle_pct)
                begin
                    @(posedge clk);
                end
            end
        end
    endtask

    // Drive the receiver stall; a hold-off request freezes it for a long stretch.
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end
            else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Check each record accepted at an edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_record('{status, operation, dest_kind, dest_register, src_kind,
                                 src_register, memory_base, displacement, immediate_value,
                                 jump_offset});
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        code_byte = 8'h00;
        send_idle_pct = 9;
        recv_idle_pct = 79;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        send_bytes();

        // Hold off the receiver while bytes keep coming, to fill the queue.
        hold_off_cycles = 60;
        while (byte_stream.size() < 40) queue_instruction();
        send_bytes();

        while (byte_stream.size() < 330) queue_instruction();
        send_bytes();

        send_idle_pct = 79;
        recv_idle_pct = 9;
        while (byte_stream.size() < 350) queue_instruction();
        send_bytes();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (byte_stream.size() < 350) queue_instruction();
        send_bytes();

        // Drain: wait until every expected record has been checked.
        while (board.pending_records.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
hdl/x86dec_pkg.sv
hdl/x86dec_front.sv
hdl/x86dec_queue.sv
hdl/x86dec_back.sv
hdl/x86_16bit_instruction_decoder_unit.sv
tb/tb_top.sv
